// ===== rtl/owsm_pkg.sv =====
// Shared types, register map, reset values and the control program of the omni wheel mixer.
package owsm_pkg;

  // Configuration port geometry and register map.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHASSIS_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_GAIN     = 3'd4;

  localparam logic [CFG_DATA_W-1:0] RST_SMOOTHING_GAIN = 16'd13107;
  localparam logic [CFG_DATA_W-1:0] RST_CHASSIS_RADIUS = 16'd13107;
  localparam logic [CFG_DATA_W-1:0] RST_FRONT_SCALE    = 16'd17203;
  localparam logic [CFG_DATA_W-1:0] RST_BACK_SCALE     = 16'd16384;
  localparam logic [CFG_DATA_W-1:0] RST_WHEEL_GAIN     = 16'd6737;

  // Unity in Q1.16, used for the complementary smoother weight.
  localparam logic [CFG_DATA_W:0] GAIN_ONE = 17'h10000;

  // Wheel speed outputs: 17-bit signed, saturated.
  localparam int OUT_W = 17;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Micro-operations executed by the datapath.
  typedef enum logic [3:0] {
    U_NOP,
    U_ACCEPT,
    U_MUL_XG,
    U_MAC_SG,
    U_ST_SM,
    U_MUL_TR,
    U_ST_ROT,
    U_MIX,
    U_MAX,
    U_DIV_INIT,
    U_DIV_STEP,
    U_DIV_ST,
    U_MUL_SG,
    U_MUL_W,
    U_ST_OUT,
    U_FINISH
  } uop_t;

  // Sequencing conditions.
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_LOOP,
    C_SKIP,
    C_WAIT_OUT
  } cond_t;

  localparam int PC_W = 6;
  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    uop_t        op;
    logic [1:0]  sel;
    cond_t       cond;
    pc_t         target;
  } ucw_t;

  localparam int  PROG_LEN  = 37;
  localparam pc_t PC_IDLE   = 6'd0;
  localparam pc_t PC_SCALE  = 6'd26;
  localparam pc_t PC_FINISH = 6'd36;

  function automatic ucw_t uc(uop_t u, logic [1:0] s, cond_t c, pc_t t);
    ucw_t w;
    w.op     = u;
    w.sel    = s;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // The control program. Smoothers, turn term, mix, limit check, four
  // normalizing divisions, scale products and four output conversions.
  localparam ucw_t PROG [PROG_LEN] = '{
    uc(U_ACCEPT,   2'd0, C_WAIT_IN,  PC_IDLE),
    uc(U_MUL_XG,   2'd0, C_NEXT,     PC_IDLE),
    uc(U_MAC_SG,   2'd0, C_NEXT,     PC_IDLE),
    uc(U_ST_SM,    2'd0, C_NEXT,     PC_IDLE),
    uc(U_MUL_XG,   2'd1, C_NEXT,     PC_IDLE),
    uc(U_MAC_SG,   2'd1, C_NEXT,     PC_IDLE),
    uc(U_ST_SM,    2'd1, C_NEXT,     PC_IDLE),
    uc(U_MUL_XG,   2'd2, C_NEXT,     PC_IDLE),
    uc(U_MAC_SG,   2'd2, C_NEXT,     PC_IDLE),
    uc(U_ST_SM,    2'd2, C_NEXT,     PC_IDLE),
    uc(U_MUL_TR,   2'd0, C_NEXT,     PC_IDLE),
    uc(U_ST_ROT,   2'd0, C_NEXT,     PC_IDLE),
    uc(U_MIX,      2'd0, C_NEXT,     PC_IDLE),
    uc(U_MAX,      2'd0, C_SKIP,     PC_SCALE),
    uc(U_DIV_INIT, 2'd0, C_NEXT,     PC_IDLE),
    uc(U_DIV_STEP, 2'd0, C_LOOP,     PC_IDLE),
    uc(U_DIV_ST,   2'd0, C_NEXT,     PC_IDLE),
    uc(U_DIV_INIT, 2'd1, C_NEXT,     PC_IDLE),
    uc(U_DIV_STEP, 2'd1, C_LOOP,     PC_IDLE),
    uc(U_DIV_ST,   2'd1, C_NEXT,     PC_IDLE),
    uc(U_DIV_INIT, 2'd2, C_NEXT,     PC_IDLE),
    uc(U_DIV_STEP, 2'd2, C_LOOP,     PC_IDLE),
    uc(U_DIV_ST,   2'd2, C_NEXT,     PC_IDLE),
    uc(U_DIV_INIT, 2'd3, C_NEXT,     PC_IDLE),
    uc(U_DIV_STEP, 2'd3, C_LOOP,     PC_IDLE),
    uc(U_DIV_ST,   2'd3, C_NEXT,     PC_IDLE),
    uc(U_MUL_SG,   2'd0, C_NEXT,     PC_IDLE),
    uc(U_MUL_SG,   2'd1, C_NEXT,     PC_IDLE),
    uc(U_MUL_W,    2'd0, C_NEXT,     PC_IDLE),
    uc(U_ST_OUT,   2'd0, C_NEXT,     PC_IDLE),
    uc(U_MUL_W,    2'd1, C_NEXT,     PC_IDLE),
    uc(U_ST_OUT,   2'd1, C_NEXT,     PC_IDLE),
    uc(U_MUL_W,    2'd2, C_NEXT,     PC_IDLE),
    uc(U_ST_OUT,   2'd2, C_NEXT,     PC_IDLE),
    uc(U_MUL_W,    2'd3, C_NEXT,     PC_IDLE),
    uc(U_ST_OUT,   2'd3, C_NEXT,     PC_IDLE),
    uc(U_FINISH,   2'd0, C_WAIT_OUT, PC_IDLE)
  };

  // Fetched for any address past the end of the program.
  localparam ucw_t UC_RECOVER = uc(U_NOP, 2'd0, C_JUMP, PC_IDLE);

endpackage

// ===== rtl/owsm_intf.sv =====
// Handshake interfaces for the chassis command and wheel speed channels.
interface owsm_cmd_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] forward_speed;
  logic signed [CW-1:0] side_speed;
  logic signed [CW-1:0] turn_rate;
  logic                 restart;

  modport source (output valid, forward_speed, side_speed, turn_rate, restart, input ready);
  modport sink (input valid, forward_speed, side_speed, turn_rate, restart, output ready);
endinterface

interface owsm_wheel_if;
  import owsm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] front_left_speed;
  logic signed [OUT_W-1:0] back_left_speed;
  logic signed [OUT_W-1:0] back_right_speed;
  logic signed [OUT_W-1:0] front_right_speed;
  logic                    was_limited;

  modport source (output valid, front_left_speed, back_left_speed, back_right_speed,
                  front_right_speed, was_limited, input ready);
  modport sink (input valid, front_left_speed, back_left_speed, back_right_speed,
                front_right_speed, was_limited, output ready);
endinterface

// ===== rtl/omni_wheel_speed_mixer_core.sv =====
// Omni wheel speed mixer: microcoded smoother, mixer, normalizer and output scaler.
//
//   channel     direction  transfer when            payload
//   in_cmd      sink       valid & ready            forward, side, turn (signed), restart
//   out_wheel   source     valid & ready            four 17-bit wheel speeds, was_limited
//   cfg_*       sink       cfg_wr_en                3-bit register index, 16-bit data
//
// A result is presented once the program has run for its command; when a wheel exceeds 1.0
// the bit-serial divider also runs once per wheel. No new command is taken until the program
// is back at idle, since in_cmd.ready is high only at the idle step. A finished result waits
// in the output register while the next command runs; the sequencer holds at its last step
// only while the previous result is untaken. Synchronous reset restores the register defaults,
// zeroes the smoothers and idles.
module omni_wheel_speed_mixer_core #(
  parameter int COMMAND_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [owsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [owsm_pkg::CFG_DATA_W-1:0]    cfg_data,
  owsm_cmd_if.sink                           in_cmd,
  owsm_wheel_if.source                       out_wheel
);
  import owsm_pkg::*;

  // Command and smoother values are signed Q4.FRAC.
  localparam int CW   = COMMAND_WIDTH;
  localparam int FRAC = CW - 4;
  // Mixed wheel values need two more bits than a command; magnitudes one more.
  localparam int WW   = CW + 2;
  localparam int MW   = CW + 1;
  // Shared multiplier operands. Operand A also carries a 16-bit scale factor.
  localparam int MA   = (WW > 17) ? WW : 17;
  localparam int MB   = 33;
  localparam int SGW  = 32;
  // Accumulator: the widest product is a normalized wheel times a 32-bit scale.
  localparam int AW   = CW + 31;
  // Divider: quotient never exceeds 1.0, so FRAC + 1 bits.
  localparam int QW   = FRAC + 1;
  localparam int RW   = CW + 2;
  localparam int CNTW = $clog2(QW);
  localparam int SM_SH  = 16;
  localparam int OUT_SH = FRAC + 12;
  localparam int VW     = AW - OUT_SH;

  localparam logic signed [AW-1:0] SM_HALF  = AW'(1) << (SM_SH - 1);
  localparam logic signed [AW-1:0] OUT_HALF = AW'(1) << (OUT_SH - 1);
  localparam logic [MW-1:0]        ONE_MAG  = MW'(1) << FRAC;
  localparam logic [QW-1:0]        ONE_Q    = QW'(1) << FRAC;
  localparam logic signed [VW-1:0] OUT_HI   = VW'(OUT_MAX);
  localparam logic signed [VW-1:0] OUT_LO   = VW'(OUT_MIN);

  function automatic logic [MW-1:0] mag_of(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] n;
    n = v[WW-1] ? -v : v;
    return n[MW-1:0];
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] gain_r, radius_r, fscale_r, bscale_r, wgain_r;

  // Sequencer.
  pc_t  pc_r, pc_nxt;
  ucw_t ctl;

  // Smoother state and working registers.
  logic signed [CW-1:0]    sm_r [3];
  logic signed [CW-1:0]    cmd_r [3];
  logic signed [CW-1:0]    rot_r;
  logic signed [WW-1:0]    w_r [4];
  logic [MW-1:0]           mx_r;
  logic                    lim_r;
  logic signed [AW-1:0]    acc_r;
  logic [RW-1:0]           rem_r;
  logic [QW-1:0]           dsh_r, quo_r;
  logic [CNTW-1:0]         cnt_r;
  logic [SGW-1:0]          sg_r [2];
  logic signed [OUT_W-1:0] res_r [4];

  // Output register.
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_spd_r [4];
  logic                    out_lim_r;
  logic                    out_busy;

  // Datapath signals.
  logic signed [MA-1:0]    mul_a;
  logic signed [MB-1:0]    mul_b;
  logic signed [MA+MB-1:0] prod;
  logic signed [AW-1:0]    prod_lo;
  logic signed [AW-1:0]    sm_sum, o_sum;
  logic signed [CW-1:0]    sm_res;
  logic signed [VW-1:0]    o_v;
  logic signed [OUT_W-1:0] o_sat;
  logic [MW-1:0]           m0, m1, m2, m3, mx01, mx23, mx_c, msel;
  logic                    lim_c;
  logic [RW-1:0]           trial, diff;
  logic                    q_bit;
  logic signed [WW-1:0]    q_ext;

  // Fetch the control word for the current step.
  assign ctl = (pc_r < PC_W'(PROG_LEN)) ? PROG[pc_r] : UC_RECOVER;

  assign in_cmd.ready = (pc_r == PC_IDLE);
  assign out_busy     = out_valid_r && !out_wheel.ready;

  assign out_wheel.valid             = out_valid_r;
  assign out_wheel.front_left_speed  = out_spd_r[0];
  assign out_wheel.back_left_speed   = out_spd_r[1];
  assign out_wheel.back_right_speed  = out_spd_r[2];
  assign out_wheel.front_right_speed = out_spd_r[3];
  assign out_wheel.was_limited       = out_lim_r;

  // Shared multiplier operand selection. Wheels 0 and 3 use the front scale product,
  // wheels 1 and 2 the back one.
  always_comb begin
    unique case (ctl.op)
      U_MUL_XG: begin
        mul_a = MA'(cmd_r[ctl.sel]);
        mul_b = MB'(gain_r);
      end
      U_MAC_SG: begin
        mul_a = MA'(sm_r[ctl.sel]);
        mul_b = MB'(GAIN_ONE - (CFG_DATA_W + 1)'(gain_r));
      end
      U_MUL_TR: begin
        mul_a = MA'(sm_r[2]);
        mul_b = MB'(radius_r);
      end
      U_MUL_SG: begin
        mul_a = MA'(ctl.sel[0] ? bscale_r : fscale_r);
        mul_b = MB'(wgain_r);
      end
      U_MUL_W: begin
        mul_a = MA'(w_r[ctl.sel]);
        mul_b = MB'(sg_r[ctl.sel[0] ^ ctl.sel[1]]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_lo = prod[AW-1:0];

  // Round half up by adding half an LSB and taking the upper bits.
  assign sm_sum = acc_r + SM_HALF;
  assign sm_res = sm_sum[SM_SH +: CW];
  assign o_sum  = acc_r + OUT_HALF;
  assign o_v    = o_sum[AW-1:OUT_SH];

  always_comb begin
    if (o_v > OUT_HI) begin
      o_sat = OUT_MAX;
    end else if (o_v < OUT_LO) begin
      o_sat = OUT_MIN;
    end else begin
      o_sat = o_v[OUT_W-1:0];
    end
  end

  // Largest wheel magnitude, and the limit decision taken at the MAX step.
  assign m0    = mag_of(w_r[0]);
  assign m1    = mag_of(w_r[1]);
  assign m2    = mag_of(w_r[2]);
  assign m3    = mag_of(w_r[3]);
  assign mx01  = (m1 > m0) ? m1 : m0;
  assign mx23  = (m3 > m2) ? m3 : m2;
  assign mx_c  = (mx23 > mx01) ? mx23 : mx01;
  assign lim_c = (mx_c > ONE_MAG);

  // One restoring division step: bring in the next dividend bit, subtract if it fits.
  assign msel  = mag_of(w_r[ctl.sel]);
  assign trial = {rem_r[RW-2:0], dsh_r[QW-1]};
  assign diff  = trial - RW'(mx_r);
  assign q_bit = (trial >= RW'(mx_r));
  assign q_ext = $signed(WW'(quo_r));

  // Next step. Waits hold the step; the loop repeats the divide step until the
  // count runs out; the limit check skips the divisions when nothing exceeds 1.0.
  always_comb begin
    unique case (ctl.cond)
      C_NEXT:     pc_nxt = pc_r + pc_t'(1);
      C_JUMP:     pc_nxt = ctl.target;
      C_WAIT_IN:  pc_nxt = in_cmd.valid ? pc_r + pc_t'(1) : pc_r;
      C_LOOP:     pc_nxt = (cnt_r != '0) ? pc_r : pc_r + pc_t'(1);
      C_SKIP:     pc_nxt = lim_c ? pc_r + pc_t'(1) : ctl.target;
      C_WAIT_OUT: pc_nxt = out_busy ? pc_r : ctl.target;
      default:    pc_nxt = PC_IDLE;
    endcase
  end

  // Control state: sequencer, configuration, smoother state and the output handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= RST_SMOOTHING_GAIN;
      radius_r    <= RST_CHASSIS_RADIUS;
      fscale_r    <= RST_FRONT_SCALE;
      bscale_r    <= RST_BACK_SCALE;
      wgain_r     <= RST_WHEEL_GAIN;
      sm_r[0]     <= '0;
      sm_r[1]     <= '0;
      sm_r[2]     <= '0;
    end else begin
      pc_r <= pc_nxt;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SMOOTHING_GAIN: gain_r   <= cfg_data;
          REG_CHASSIS_RADIUS: radius_r <= cfg_data;
          REG_FRONT_SCALE:    fscale_r <= cfg_data;
          REG_BACK_SCALE:     bscale_r <= cfg_data;
          REG_WHEEL_GAIN:     wgain_r  <= cfg_data;
          default: ;
        endcase
      end

      // A restart command clears the smoothers before its own update.
      if (ctl.op == U_ACCEPT && in_cmd.valid && in_cmd.restart) begin
        sm_r[0] <= '0;
        sm_r[1] <= '0;
        sm_r[2] <= '0;
      end else if (ctl.op == U_ST_SM) begin
        sm_r[ctl.sel] <= sm_res;
      end

      if (ctl.op == U_FINISH && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_wheel.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      U_ACCEPT: begin
        if (in_cmd.valid) begin
          cmd_r[0] <= in_cmd.forward_speed;
          cmd_r[1] <= in_cmd.side_speed;
          cmd_r[2] <= in_cmd.turn_rate;
        end
      end
      U_MUL_XG, U_MUL_TR, U_MUL_W: acc_r <= prod_lo;
      U_MAC_SG: acc_r <= acc_r + prod_lo;
      U_ST_ROT: rot_r <= sm_res;
      U_MIX: begin
        w_r[0] <=  WW'(sm_r[0]) + WW'(sm_r[1]) + WW'(rot_r);
        w_r[1] <=  WW'(sm_r[0]) - WW'(sm_r[1]) + WW'(rot_r);
        w_r[2] <= -WW'(sm_r[0]) - WW'(sm_r[1]) + WW'(rot_r);
        w_r[3] <= -WW'(sm_r[0]) + WW'(sm_r[1]) + WW'(rot_r);
      end
      U_MAX: begin
        mx_r  <= mx_c;
        lim_r <= lim_c;
      end
      U_DIV_INIT: begin
        // The dividend is |w| shifted up by FRAC; its top part, |w| / 2, is already
        // below the divisor, so only the last FRAC + 1 bits need steps.
        rem_r <= RW'(msel >> 1);
        dsh_r <= QW'(msel[0]) << FRAC;
        quo_r <= '0;
        cnt_r <= CNTW'(FRAC);
      end
      U_DIV_STEP: begin
        rem_r <= q_bit ? diff : trial;
        quo_r <= {quo_r[QW-2:0], q_bit};
        dsh_r <= dsh_r << 1;
        cnt_r <= cnt_r - CNTW'(1);
      end
      U_DIV_ST: w_r[ctl.sel] <= w_r[ctl.sel][WW-1] ? -q_ext : q_ext;
      U_MUL_SG: sg_r[ctl.sel[0]] <= prod[SGW-1:0];
      U_ST_OUT: res_r[ctl.sel] <= o_sat;
      U_FINISH: begin
        if (!out_busy) begin
          out_spd_r[0] <= res_r[0];
          out_spd_r[1] <= res_r[1];
          out_spd_r[2] <= res_r[2];
          out_spd_r[3] <= res_r[3];
          out_lim_r    <= lim_r;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // The sequencer never runs past the end of its program.
  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r < PC_W'(PROG_LEN))
    else $error("sequencer left the program");

  // A result appears only when the last step hands it over.
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r) == PC_FINISH)
    else $error("result raised outside the finish step");

  // Leaving the idle step means a command was taken.
  a_leave_idle_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(pc_r) == PC_IDLE && pc_r != PC_IDLE) |-> $past(in_cmd.valid))
    else $error("sequencer started without a command");

  // A normalized magnitude never exceeds 1.0.
  a_quotient_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == U_DIV_ST) |-> (quo_r <= ONE_Q))
    else $error("normalized wheel magnitude above one");

  // The limit flag handed out matches the stored maximum.
  a_limit_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_FINISH && lim_r) |-> (mx_r > ONE_MAG))
    else $error("limit flag without an oversized wheel");
`endif

endmodule
